@@ hw/rtl/pcs_pkg.sv @@
// types, constants and microcode table shared by the pid step controller
package pcs_pkg;

   // datapath widths
   localparam int ERR_W      = 17;              // setpoint - measured
   localparam int DERIV_W    = 18;              // error - last error
   localparam int INTEG_W    = 34;              // integral, q18.16
   localparam int ISUM_W     = INTEG_W + 1;     // integral before clamp
   localparam int MA_W       = INTEG_W;         // multiplier operand a
   localparam int MB_W       = 17;              // multiplier operand b
   localparam int PROD_W     = MA_W + MB_W;
   localparam int ACC_W      = 53;              // term sum, q.24
   localparam int FRAC_SH    = 16;              // q.8 terms to q.24
   localparam int ROUND_SH   = 24;
   localparam int DRIVE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // opcodes and loop modes
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;
   localparam logic MODE_PID = 1'b0;
   localparam logic MODE_PD  = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN,
      CSR_DERIV_GAIN,
      CSR_INTEG_GAIN,
      CSR_INTEG_STEP,
      CSR_INTEG_LIMIT,
      CSR_LOOP_MODE
   } csr_idx_type;

   // beat payloads
   typedef struct packed {
      logic               opcode;
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      integ_at_limit;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] deriv_gain;
      logic signed [15:0] integ_gain;
      logic [15:0]        integ_step;
      logic [15:0]        integ_limit;
      logic               loop_mode;
   } cfg_type;

   // microprogram steps
   typedef enum logic [2:0] {
      STEP_FETCH,
      STEP_IMUL,
      STEP_IUPD,
      STEP_PD1,
      STEP_PD2,
      STEP_IADD,
      STEP_OUT,
      STEP_CLEAR
   } step_type;

   typedef enum logic [1:0] {MA_ERR, MA_DERIV, MA_INTEG} mul_a_type;
   typedef enum logic [1:0] {MB_PROP, MB_DERIV, MB_INTEG, MB_STEP} mul_b_type;
   typedef enum logic [2:0] {ACC_HOLD, ACC_ZERO, ACC_LOAD_HI, ACC_ADD_HI, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_CLEAR, JMP_PD} jmp_type;

   // one control word per step
   typedef struct packed {
      logic       wait_in;
      logic       wait_out;
      jmp_type    jmp;
      step_type   target;
      logic       mul_en;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      logic       err_upd;
      logic       integ_upd;
      logic       state_clr;
   } ctrl_word_type;

   // microcode rom
   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         STEP_FETCH: begin
            w.wait_in = 1'b1;
            w.jmp     = JMP_CLEAR;
            w.target  = STEP_CLEAR;
         end
         STEP_IMUL: begin
            w.mul_en  = 1'b1;
            w.mul_a   = MA_ERR;
            w.mul_b   = MB_STEP;
            w.err_upd = 1'b1;
         end
         STEP_IUPD: begin
            w.integ_upd = 1'b1;
            w.mul_en    = 1'b1;
            w.mul_a     = MA_ERR;
            w.mul_b     = MB_PROP;
         end
         STEP_PD1: begin
            w.acc_op = ACC_LOAD_HI;
            w.mul_en = 1'b1;
            w.mul_a  = MA_DERIV;
            w.mul_b  = MB_DERIV;
         end
         STEP_PD2: begin
            w.acc_op = ACC_ADD_HI;
            w.mul_en = 1'b1;
            w.mul_a  = MA_INTEG;
            w.mul_b  = MB_INTEG;
            w.jmp    = JMP_PD;
            w.target = STEP_OUT;
         end
         STEP_IADD: begin
            w.acc_op = ACC_ADD;
         end
         STEP_OUT: begin
            w.wait_out = 1'b1;
            w.jmp      = JMP_ALWAYS;
            w.target   = STEP_FETCH;
         end
         STEP_CLEAR: begin
            w.state_clr = 1'b1;
            w.acc_op    = ACC_ZERO;
            w.jmp       = JMP_ALWAYS;
            w.target    = STEP_OUT;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/pcs_datapath.sv @@
// pid datapath: error, integral with clamp, shared multiplier and term accumulator
module pcs_datapath
   import pcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_word_type             cw,
   input  cfg_type                   cfg,
   input  logic                      load_err,
   input  logic signed [15:0]        setpoint,
   input  logic signed [15:0]        measured,
   output logic signed [DRIVE_W-1:0] drive,
   output logic                      at_limit
);

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic                      flag_ff, flag_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [ISUM_W-1:0]  isum, lim_pos, lim_neg;
   logic signed [ACC_W-1:0]   prod_hi, rnd;
   logic                      integ_en;

   // operand select and multiply
   always_comb begin
      case (cw.mul_a)
         MA_ERR:   mul_a = MA_W'(err_ff);
         MA_DERIV: mul_a = MA_W'(deriv_ff);
         MA_INTEG: mul_a = integ_ff;
         default:  mul_a = '0;
      endcase
      case (cw.mul_b)
         MB_PROP:  mul_b = MB_W'(cfg.prop_gain);
         MB_DERIV: mul_b = MB_W'(cfg.deriv_gain);
         MB_INTEG: mul_b = MB_W'(cfg.integ_gain);
         MB_STEP:  mul_b = $signed({1'b0, cfg.integ_step});
         default:  mul_b = '0;
      endcase
      prod_in = cw.mul_en ? mul_a * mul_b : prod_ff;
   end

   // integral add and clamp to +/- limit
   assign isum     = ISUM_W'(integ_ff) + prod_ff[ISUM_W-1:0];
   assign lim_pos  = $signed({3'b000, cfg.integ_limit, {FRAC_SH{1'b0}}});
   assign lim_neg  = -lim_pos;
   assign integ_en = cw.integ_upd && (cfg.loop_mode == MODE_PID);

   always_comb begin
      err_in   = load_err ? ERR_W'(setpoint) - ERR_W'(measured) : err_ff;
      prev_in  = prev_ff;
      deriv_in = deriv_ff;
      integ_in = integ_ff;
      flag_in  = flag_ff;
      if (cw.err_upd) begin
         deriv_in = DERIV_W'(err_ff) - DERIV_W'(prev_ff);
         prev_in  = err_ff;
         flag_in  = 1'b0;
      end
      if (integ_en) begin
         if (isum > lim_pos) begin
            integ_in = lim_pos[INTEG_W-1:0];
            flag_in  = 1'b1;
         end else if (isum < lim_neg) begin
            integ_in = lim_neg[INTEG_W-1:0];
            flag_in  = 1'b1;
         end else begin
            integ_in = isum[INTEG_W-1:0];
         end
      end
      if (cw.state_clr) begin
         prev_in  = '0;
         integ_in = '0;
         flag_in  = 1'b0;
      end
   end

   // term accumulator in q.24
   assign prod_hi = $signed({prod_ff[ACC_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}});

   always_comb begin
      case (cw.acc_op)
         ACC_ZERO:    acc_in = '0;
         ACC_LOAD_HI: acc_in = prod_hi;
         ACC_ADD_HI:  acc_in = acc_ff + prod_hi;
         ACC_ADD:     acc_in = acc_ff + ACC_W'(prod_ff);
         default:     acc_in = acc_ff;
      endcase
   end

   // stored controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         integ_ff <= integ_in;
         flag_ff  <= flag_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   // round half up; the sum stays far inside 32 bits so sign extension is exact
   assign rnd      = acc_ff + ACC_W'(1 << (ROUND_SH - 1));
   assign drive    = DRIVE_W'($signed(rnd[ACC_W-1:ROUND_SH]));
   assign at_limit = flag_ff;

endmodule

@@ hw/rtl/pid_controller_step.sv @@
// top level of the pid step controller: csr bank, microcode sequencer, result register
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  req      | req_valid / req_stall     | opcode, setpoint, measured
//  rsp      | rsp_valid / rsp_stall     | drive, integ_at_limit
//  csr      | csr_wr_en                 | csr_index, csr_wdata
//
// a control step runs one microcode step at a time, fetch included: fetch, imul,
// iupd, pd1, pd2, iadd and out in pid mode, the pid steps without iadd in pd mode,
// and fetch, clear and out for a clear; the result register loads as out completes.
// the sequence is set by the one shared 34x17 multiplier that forms every product in turn.
// reset is synchronous, active high; it loads the register defaults and
// zeroes the integral and last error.
// req_stall is low only in the fetch step; the next beat is taken while the
// previous result still waits in the result register, and the output step
// holds while that register is full and stalled.
module pid_controller_step
   import pcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                   cfg_ff, cfg_in;
   step_type                  step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   ctrl_word_type             cw;
   logic                      req_accept, out_room, hold, taken, emit;
   logic signed [DRIVE_W-1:0] dp_drive;
   logic                      dp_at_limit;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:   cfg_in.prop_gain   = $signed(csr_wdata);
            CSR_DERIV_GAIN:  cfg_in.deriv_gain  = $signed(csr_wdata);
            CSR_INTEG_GAIN:  cfg_in.integ_gain  = $signed(csr_wdata);
            CSR_INTEG_STEP:  cfg_in.integ_step  = csr_wdata;
            CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata;
            CSR_LOOP_MODE:   cfg_in.loop_mode   = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer: fetch control word, hold on handshakes, branch or advance
   assign cw         = ctrl_rom(step_ff);
   assign req_stall  = !cw.wait_in;
   assign req_accept = req_valid && cw.wait_in;
   assign out_room   = !rsp_valid_ff || !rsp_stall;
   assign hold       = (cw.wait_in && !req_valid) || (cw.wait_out && !out_room);
   assign emit       = cw.wait_out && out_room;

   always_comb begin
      case (cw.jmp)
         JMP_ALWAYS: taken = 1'b1;
         JMP_CLEAR:  taken = (req_payload.opcode == OP_CLEAR);
         JMP_PD:     taken = (cfg_ff.loop_mode == MODE_PD);
         default:    taken = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = cw.target;
      end else begin
         step_in = step_type'(step_ff + 3'd1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_data_in.drive          = dp_drive;
         rsp_data_in.integ_at_limit = dp_at_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_FETCH;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{prop_gain: 16'sd256, deriv_gain: 16'sd0, integ_gain: 16'sd0,
                           integ_step: 16'd328, integ_limit: 16'd5000,
                           loop_mode: MODE_PID};
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // datapath
   pcs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cw       (cw),
      .cfg      (cfg_ff),
      .load_err (req_accept),
      .setpoint (req_payload.setpoint),
      .measured (req_payload.measured),
      .drive    (dp_drive),
      .at_limit (dp_at_limit)
   );

`ifndef ASSERT_OFF
   // a clear beat goes straight to the clear step
   a_clear_branch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.opcode == OP_CLEAR)
         |=> (step_ff == STEP_CLEAR))
      else $error("clear beat did not branch to clear step");

   // a control beat starts the integral multiply
   a_step_branch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.opcode == OP_STEP)
         |=> (step_ff == STEP_IMUL))
      else $error("control beat did not start the step sequence");

   // leaving the output step always leaves a result waiting
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_OUT && out_room) |=> (rsp_valid && step_ff == STEP_FETCH))
      else $error("output step finished without a result");

   // a clear beat yields a zero result
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CLEAR) ##1 (step_ff == STEP_OUT && out_room)
         |=> (rsp_payload.drive == '0 && !rsp_payload.integ_at_limit))
      else $error("clear beat gave a nonzero result");
`endif

endmodule
